/* hdl/fss_pkg.sv */
// shared types, constants and the nice-to-weight table for the fair-share scheduler
// no dependencies
package fss_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int VR_W       = 32;
  localparam int NICE_W     = 6;
  localparam int ENTRY_W    = VR_W + NICE_W;
  localparam int CFG_W      = 16;
  localparam int WEIGHT_W   = 17;
  localparam int WSUM_W     = WEIGHT_W + CNT_W;
  localparam int PERIOD_W   = CFG_W + CNT_W;
  localparam int DIV_NUM_W  = PERIOD_W + WEIGHT_W;
  localparam int DIV_DEN_W  = WSUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
  localparam int SLICE_W    = 24;
  localparam int APB_ADDR_W = 3;

  localparam logic [SLICE_W-1:0] SLICE_MAX = {SLICE_W{1'b1}};
  localparam logic [NICE_W-1:0]  NICE_MAX  = NICE_W'(39);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_PICK  = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic REG_LATENCY  = 1'b0;
  localparam logic REG_MIN_GRAN = 1'b1;

  localparam logic [CFG_W-1:0] LATENCY_RST  = 16'd20;
  localparam logic [CFG_W-1:0] MIN_GRAN_RST = 16'd4;

  typedef struct packed {
    logic [CFG_W-1:0] latency;
    logic [CFG_W-1:0] min_gran;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  localparam logic [WEIGHT_W-1:0] WEIGHTS [40] = '{
    17'd88761, 17'd71755, 17'd56483, 17'd46273, 17'd36291, 17'd29154, 17'd23254, 17'd18705,
    17'd14949, 17'd11916, 17'd9548,  17'd7620,  17'd6100,  17'd4904,  17'd3906,  17'd3121,
    17'd2501,  17'd1991,  17'd1586,  17'd1277,  17'd1024,  17'd820,   17'd655,   17'd526,
    17'd423,   17'd335,   17'd272,   17'd215,   17'd172,   17'd137,   17'd110,   17'd87,
    17'd70,    17'd56,    17'd45,    17'd36,    17'd29,    17'd23,    17'd18,    17'd15
  };

  // levels above the table use the lightest weight
  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [NICE_W-1:0] nice);
    logic [NICE_W-1:0] n;
    n = (nice > NICE_MAX) ? NICE_MAX : nice;
    return WEIGHTS[n];
  endfunction

endpackage

/* hdl/fss_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module fss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/fss_div.sv */
// iterative restoring divider, one quotient bit per cycle
// depends on fss_pkg
module fss_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [fss_pkg::DIV_NUM_W-1:0]  dividend,
  input  logic [fss_pkg::DIV_DEN_W-1:0]  divisor,
  output logic                           done,
  output logic [fss_pkg::DIV_NUM_W-1:0]  quotient
);

  logic                          busy;
  logic [fss_pkg::DIV_CNT_W-1:0] cnt;
  logic [fss_pkg::DIV_DEN_W-1:0] rem;
  logic [fss_pkg::DIV_DEN_W-1:0] den;
  logic [fss_pkg::DIV_DEN_W:0]   rem_sh;
  logic [fss_pkg::DIV_DEN_W:0]   rem_sub;
  logic                          fits;

  assign rem_sh  = {rem, quotient[fss_pkg::DIV_NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= fss_pkg::DIV_CNT_W'(fss_pkg::DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == fss_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (busy) begin
      rem      <= fits ? rem_sub[fss_pkg::DIV_DEN_W-1:0] : rem_sh[fss_pkg::DIV_DEN_W-1:0];
      quotient <= {quotient[fss_pkg::DIV_NUM_W-2:0], fits};
    end
  end

endmodule

/* hdl/fss_cfg.sv */
// apb register file holding scheduling latency and minimum granularity
// depends on fss_pkg
module fss_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fss_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output fss_pkg::cfg_t                   cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.latency  <= fss_pkg::LATENCY_RST;
      cfg.min_gran <= fss_pkg::MIN_GRAN_RST;
    end else if (wr) begin
      case (paddr[2])
        fss_pkg::REG_LATENCY:  cfg.latency  <= pwdata[fss_pkg::CFG_W-1:0];
        fss_pkg::REG_MIN_GRAN: cfg.min_gran <= pwdata[fss_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      fss_pkg::REG_LATENCY:  prdata = 32'(cfg.latency);
      fss_pkg::REG_MIN_GRAN: prdata = 32'(cfg.min_gran);
      default:               prdata = '0;
    endcase
  end

endmodule

/* hdl/fair_share_pick_next_scheduler.sv */
// top level of the fair-share pick-next scheduler: control sequencer, ready flags, scan datapath
// depends on fss_pkg, fss_ram, fss_div, fss_cfg
//
// One request word is taken at a time. A write (opcode 0), stop (opcode 2) or unused (opcode 3)
// word returns its all-zero response through the output state. A pick (opcode 1) scans the slot
// memory one entry per cycle through its single read port, then passes the evaluate state and,
// if a slot is found, the multiply state and a 40-step restoring divide for the time slice. The
// response sits in an output register, so a new request is accepted while the previous response
// still waits for rsp_ready. Virtual runtime and nice level live in the slot memory; ready flags
// are flip-flops cleared by reset. Configuration is written over the apb port at byte address 0
// (scheduling latency) and 4 (min_granularity).
module fair_share_pick_next_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [1:0]                      opcode,
  input  logic [5:0]                      slot,
  input  logic                            ready_req,
  input  logic [31:0]                     vruntime,
  input  logic [5:0]                      nice,
  // response channel
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [5:0]                      chosen_slot,
  output logic                            none_ready,
  output logic [23:0]                     time_slice,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fss_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  fss_pkg::state_t state, state_next;
  fss_pkg::cfg_t   cfg;

  // task table control state
  logic [fss_pkg::SLOTS-1:0]   ready_flags;
  logic                        running_valid;
  logic [fss_pkg::SLOT_W-1:0]  running_slot;

  // scan state
  logic [fss_pkg::CNT_W-1:0]    rd_cnt;
  logic                         cmp_vld;
  logic [fss_pkg::SLOT_W-1:0]   cmp_idx;
  logic                         found;
  logic [fss_pkg::SLOT_W-1:0]   best_idx;
  logic [fss_pkg::VR_W-1:0]     best_vr;
  logic [fss_pkg::WEIGHT_W-1:0] best_wt;
  logic [fss_pkg::CNT_W-1:0]    tot_cnt;
  logic [fss_pkg::WSUM_W-1:0]   tot_wsum;

  // slice arithmetic
  logic [fss_pkg::PERIOD_W-1:0]  thr_prod;
  logic [fss_pkg::PERIOD_W-1:0]  alt_period;
  logic [fss_pkg::PERIOD_W-1:0]  period;
  logic [fss_pkg::CNT_W-1:0]     cnt_m1;
  logic [fss_pkg::DIV_NUM_W-1:0] numer;
  logic [fss_pkg::DIV_NUM_W:0]   slice_sum;
  logic [fss_pkg::DIV_NUM_W-1:0] div_q;
  logic                          div_done;

  // pending response
  logic [5:0]                   res_slot;
  logic                         res_none;
  logic [fss_pkg::SLICE_W-1:0]  res_slice;

  // memory ports
  logic                         ram_we;
  logic                         ram_re;
  logic                         div_start;
  logic                         req_fire;
  logic                         slot_ok;
  logic                         rsp_load;
  logic [fss_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [fss_pkg::VR_W-1:0]     rd_vr;
  logic [fss_pkg::WEIGHT_W-1:0] rd_wt;

  fss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fss_ram #(
    .WIDTH (fss_pkg::ENTRY_W),
    .DEPTH (fss_pkg::SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fss_pkg::SLOT_W'(slot)),
    .wdata ({vruntime, nice}),
    .re    (ram_re),
    .raddr (rd_cnt[fss_pkg::SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  fss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (numer),
    .divisor  (tot_wsum),
    .done     (div_done),
    .quotient (div_q)
  );

  assign req_fire = req_valid & req_ready;
  assign slot_ok  = {5'd0, slot} < 11'(fss_pkg::SLOTS);
  assign rsp_load = (state == fss_pkg::ST_OUT) && (!rsp_valid || rsp_ready);
  assign rd_vr    = ram_rdata[fss_pkg::ENTRY_W-1:fss_pkg::NICE_W];
  assign rd_wt    = fss_pkg::weight_of(ram_rdata[fss_pkg::NICE_W-1:0]);

  // ready count after the pick is the scanned count less the chosen slot
  assign cnt_m1   = tot_cnt - fss_pkg::CNT_W'(1);

  // period widens once more tasks are ready than latency / min_gran allows
  assign period   = (thr_prod > fss_pkg::PERIOD_W'(cfg.latency)) ? alt_period
                                                                  : fss_pkg::PERIOD_W'(cfg.latency);
  assign numer    = fss_pkg::DIV_NUM_W'(period) * fss_pkg::DIV_NUM_W'(best_wt);
  assign slice_sum = (fss_pkg::DIV_NUM_W + 1)'(cfg.min_gran) + (fss_pkg::DIV_NUM_W + 1)'(div_q);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fss_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_next = (opcode == fss_pkg::OP_PICK) ? fss_pkg::ST_SCAN : fss_pkg::ST_OUT;
        end
      end
      fss_pkg::ST_SCAN: begin
        if (rd_cnt == fss_pkg::CNT_W'(fss_pkg::SLOTS)) begin
          state_next = fss_pkg::ST_EVAL;
        end
      end
      fss_pkg::ST_EVAL: state_next = found ? fss_pkg::ST_MUL : fss_pkg::ST_OUT;
      fss_pkg::ST_MUL:  state_next = fss_pkg::ST_DIV;
      fss_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = fss_pkg::ST_OUT;
        end
      end
      fss_pkg::ST_OUT: begin
        if (rsp_load) begin
          state_next = fss_pkg::ST_IDLE;
        end
      end
      default: state_next = fss_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    div_start = 1'b0;
    case (state)
      fss_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        ram_we    = req_valid && (opcode == fss_pkg::OP_WRITE) && slot_ok;
      end
      fss_pkg::ST_SCAN: ram_re    = rd_cnt < fss_pkg::CNT_W'(fss_pkg::SLOTS);
      fss_pkg::ST_MUL:  div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ready flags and running slot
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flags   <= '0;
      running_valid <= 1'b0;
      running_slot  <= '0;
    end else begin
      if (state == fss_pkg::ST_IDLE && req_fire) begin
        case (opcode)
          fss_pkg::OP_WRITE: begin
            if (slot_ok) begin
              ready_flags[fss_pkg::SLOT_W'(slot)] <= ready_req;
            end
          end
          fss_pkg::OP_PICK: begin
            // the running task goes back to the ready set before the scan
            if (running_valid) begin
              ready_flags[running_slot] <= 1'b1;
            end
            running_valid <= 1'b0;
          end
          fss_pkg::OP_STOP: running_valid <= 1'b0;
          default: ;
        endcase
      end else if (state == fss_pkg::ST_EVAL && found) begin
        ready_flags[best_idx] <= 1'b0;
        running_valid         <= 1'b1;
        running_slot          <= best_idx;
      end
    end
  end

  // scan read pointer; the compare stage runs in the cycle after the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_cnt[fss_pkg::SLOT_W-1:0];
    if (state == fss_pkg::ST_IDLE) begin
      rd_cnt   <= '0;
      found    <= 1'b0;
      tot_cnt  <= '0;
      tot_wsum <= '0;
    end else begin
      if (ram_re) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (cmp_vld && ready_flags[cmp_idx]) begin
        tot_cnt  <= tot_cnt + 1'b1;
        tot_wsum <= tot_wsum + fss_pkg::WSUM_W'(rd_wt);
        // less-or-equal lets a later index win a tie
        if (!found || rd_vr <= best_vr) begin
          found    <= 1'b1;
          best_idx <= cmp_idx;
          best_vr  <= rd_vr;
          best_wt  <= rd_wt;
        end
      end
    end
  end

  // threshold test as count * min_gran > latency avoids a divide
  always_ff @(posedge clk) begin
    if (state == fss_pkg::ST_EVAL) begin
      thr_prod   <= fss_pkg::PERIOD_W'(cnt_m1) * fss_pkg::PERIOD_W'(cfg.min_gran);
      alt_period <= fss_pkg::PERIOD_W'(tot_cnt) * fss_pkg::PERIOD_W'(cfg.min_gran);
    end
  end

  // pending response fields
  always_ff @(posedge clk) begin
    case (state)
      fss_pkg::ST_IDLE: begin
        res_slot  <= '0;
        res_none  <= 1'b0;
        res_slice <= '0;
      end
      fss_pkg::ST_EVAL: begin
        if (!found) begin
          res_none  <= 1'b1;
          res_slice <= fss_pkg::SLICE_W'(cfg.min_gran);
        end
      end
      fss_pkg::ST_DIV: begin
        if (div_done) begin
          res_slot  <= 6'(best_idx);
          res_slice <= (slice_sum > (fss_pkg::DIV_NUM_W + 1)'(fss_pkg::SLICE_MAX))
                       ? fss_pkg::SLICE_MAX : slice_sum[fss_pkg::SLICE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      chosen_slot <= res_slot;
      none_ready  <= res_none;
      time_slice  <= res_slice;
    end
  end

endmodule

/* hdl/fss_checker.sv */
// port-level checks for the fair-share scheduler, bound to the top level
// depends on fair_share_pick_next_scheduler
module fss_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [5:0]  chosen_slot,
  input logic        none_ready,
  input logic [23:0] time_slice
);

  // a stalled response word holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(chosen_slot) && $stable(none_ready)
                               && $stable(time_slice))
    else $error("response word changed while stalled");

  // one request in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // idle pick reports slot zero
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && none_ready |-> chosen_slot == 6'd0)
    else $error("idle response with nonzero slot");

  // out of reset ready for a request with no response pending
  assert property (@(posedge clk)
    rst |=> req_ready && !rsp_valid)
    else $error("bad state after reset");

endmodule

bind fair_share_pick_next_scheduler fss_checker u_fss_checker (.*);

/* sim/tb_top.sv */
// self-checking bench for fair_share_pick_next_scheduler: directed script, then random phases
// depends on fss_pkg and the scheduler rtl; every response word is checked against an expected word
`timescale 1ns / 100ps

module tb_top;

  // opcode 3 is unused by the block, it must leave all state alone
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int NUM_PHASES = 8;

  // one request word as driven on the port
  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  slot;
    logic        rdy;
    logic [31:0] vr;
    logic [5:0]  nice;
  } sched_req_t;

  // one response word
  typedef struct packed {
    logic [5:0]  chosen;
    logic        idle;
    logic [23:0] slice;
  } sched_rsp_t;

  // directed row: typed set means the response is written in by hand
  typedef struct packed {
    sched_req_t w;
    logic       typed;
    sched_rsp_t want;
  } script_row_t;

  // nice level to load weight, levels above 39 clamp to the lightest
  localparam int unsigned NICE_WEIGHT [40] = '{
    88761, 71755, 56483, 46273, 36291, 29154, 23254, 18705,
    14949, 11916, 9548,  7620,  6100,  4904,  3906,  3121,
    2501,  1991,  1586,  1277,  1024,  820,   655,   526,
    423,   335,   272,   215,   172,   137,   110,   87,
    70,    56,    45,    36,    29,    23,    18,    15
  };

  localparam sched_rsp_t ZERO_RSP = '{6'd0, 1'b0, 24'd0};
  localparam sched_rsp_t IDLE_RST = '{6'd0, 1'b1, 24'd4};

  // directed script, run under reset configuration (LATENCY_RST and MIN_GRAN_RST from fss_pkg)
  script_row_t script [18] = '{
    '{'{fss_pkg::OP_PICK, 6'd0, 1'b0, 32'h0000_0000, 6'd0}, 1'b1, IDLE_RST}, // pick on empty table
    '{'{fss_pkg::OP_STOP, 6'd0, 1'b0, 32'h0000_0000, 6'd0}, 1'b1, ZERO_RSP}, // stop, none running
    '{'{OP_NONE, 6'd63, 1'b1, 32'hFFFF_FFFF, 6'd63}, 1'b1, ZERO_RSP}, // unused opcode
    '{'{fss_pkg::OP_WRITE, 6'd0, 1'b1, 32'h0000_0000, 6'd0}, 1'b1, ZERO_RSP},
    '{'{fss_pkg::OP_WRITE, 6'd63, 1'b1, 32'h0000_0000, 6'd39}, 1'b1, ZERO_RSP}, // ties slot 0
    '{'{fss_pkg::OP_WRITE, 6'd31, 1'b1, 32'hFFFF_FFFF, 6'd63}, 1'b1, ZERO_RSP}, // nice past table
    '{'{fss_pkg::OP_WRITE, 6'd17, 1'b1, 32'h0000_002A, 6'd40}, 1'b1, ZERO_RSP},
    '{'{fss_pkg::OP_PICK, 6'd0, 1'b0, 32'h0000_0000, 6'd0}, 1'b0, ZERO_RSP}, // tie, high index wins
    '{'{fss_pkg::OP_PICK, 6'd0, 1'b0, 32'h0000_0000, 6'd0}, 1'b0, ZERO_RSP}, // running slot back
    '{'{fss_pkg::OP_STOP, 6'd0, 1'b0, 32'h0000_0000, 6'd0}, 1'b1, ZERO_RSP},
    '{'{fss_pkg::OP_PICK, 6'd0, 1'b0, 32'h0000_0000, 6'd0}, 1'b0, ZERO_RSP},
    '{'{fss_pkg::OP_WRITE, 6'd0, 1'b0, 32'h0000_0005, 6'd20}, 1'b1, ZERO_RSP}, // rewrite running
    '{'{fss_pkg::OP_PICK, 6'd0, 1'b0, 32'h0000_0000, 6'd0}, 1'b0, ZERO_RSP},
    '{'{fss_pkg::OP_STOP, 6'd0, 1'b0, 32'h0000_0000, 6'd0}, 1'b1, ZERO_RSP},
    '{'{fss_pkg::OP_WRITE, 6'd31, 1'b0, 32'h0000_0000, 6'd0}, 1'b1, ZERO_RSP},
    '{'{fss_pkg::OP_PICK, 6'd0, 1'b0, 32'h0000_0000, 6'd0}, 1'b0, ZERO_RSP}, // lone ready slot
    '{'{fss_pkg::OP_STOP, 6'd0, 1'b0, 32'h0000_0000, 6'd0}, 1'b1, ZERO_RSP},
    '{'{fss_pkg::OP_PICK, 6'd0, 1'b0, 32'h0000_0000, 6'd0}, 1'b1, IDLE_RST}  // drained again
  };

  // random phases: configuration, share of ready writes, idling off, number of words
  int unsigned ph_latency [NUM_PHASES] = '{20, 65535, 1,     65535, 1,  100, 0,   20};
  int unsigned ph_gran    [NUM_PHASES] = '{4,  1,     65535, 65535, 1,  0,   0,   4};
  int unsigned ph_ready   [NUM_PHASES] = '{70, 80,    60,    50,    85, 65,  40,  30};
  bit          ph_quiet   [NUM_PHASES] = '{0,  0,     0,     0,     0,  0,   1,   0};
  int unsigned ph_words   [NUM_PHASES] = '{150, 150,  130,   120,   150, 100, 120, 110};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  opcode = fss_pkg::OP_WRITE;
  logic [5:0]  slot = '0;
  logic        ready_req = 1'b0;
  logic [31:0] vruntime = '0;
  logic [5:0]  nice = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [5:0]  chosen_slot;
  logic        none_ready;
  logic [23:0] time_slice;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [fss_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the scheduler state and configuration
  logic        tbl_ready [fss_pkg::SLOTS];
  logic [31:0] tbl_vr    [fss_pkg::SLOTS];
  logic [5:0]  tbl_nice  [fss_pkg::SLOTS];
  logic        run_valid = 1'b0;
  logic [5:0]  run_slot = '0;
  logic [15:0] cfg_latency = 16'd20;
  logic [15:0] cfg_gran = 16'd4;

  sched_rsp_t  pending_rsp [$];   // predicted response words, oldest first
  int unsigned bad_words = 0;
  bit          quiet = 1'b0;      // no idling on either side while set

  fair_share_pick_next_scheduler u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .opcode      (opcode),
    .slot        (slot),
    .ready_req   (ready_req),
    .vruntime    (vruntime),
    .nice        (nice),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .chosen_slot (chosen_slot),
    .none_ready  (none_ready),
    .time_slice  (time_slice),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk = ~clk;

  initial begin
    for (int i = 0; i < fss_pkg::SLOTS; i++) begin
      tbl_ready[i] = 1'b0;
      tbl_vr[i]    = '0;
      tbl_nice[i]  = '0;
    end
  end

  function automatic longint unsigned load_weight(input logic [5:0] lvl);
    return NICE_WEIGHT[(lvl > 6'd39) ? 39 : lvl];
  endfunction

  // apply one request word to the predictor state and return its response word
  function automatic sched_rsp_t schedule_step(input sched_req_t w);
    sched_rsp_t r;
    bit found;
    int unsigned best;
    logic [31:0] best_vr;
    longint unsigned count, wsum, wt, thresh, period, slice;
    r = '0;
    if (w.op == fss_pkg::OP_WRITE) begin
      tbl_ready[w.slot] = w.rdy;
      tbl_vr[w.slot]    = w.vr;
      tbl_nice[w.slot]  = w.nice;
    end else if (w.op == fss_pkg::OP_STOP) begin
      run_valid = 1'b0;
    end else if (w.op == fss_pkg::OP_PICK) begin
      // the running slot rejoins the ready set before the scan
      if (run_valid) tbl_ready[run_slot] = 1'b1;
      run_valid = 1'b0;
      found = 1'b0;
      best = 0;
      best_vr = '0;
      // least virtual runtime, later index wins a tie
      for (int i = 0; i < fss_pkg::SLOTS; i++) begin
        if (tbl_ready[i] && (!found || tbl_vr[i] <= best_vr)) begin
          best = i;
          best_vr = tbl_vr[i];
          found = 1'b1;
        end
      end
      if (!found) begin
        r.idle  = 1'b1;
        r.slice = 24'(cfg_gran);
      end else begin
        tbl_ready[best] = 1'b0;
        run_valid = 1'b1;
        run_slot  = 6'(best);
        // load of what is still ready after the pick
        count = 0;
        wsum  = 0;
        for (int i = 0; i < fss_pkg::SLOTS; i++) begin
          if (tbl_ready[i]) begin
            count++;
            wsum += load_weight(tbl_nice[i]);
          end
        end
        // zero granularity means no limit on the ready count
        thresh = (cfg_gran == 16'd0) ? 64'hFFFF_FFFF : cfg_latency / cfg_gran;
        period = (count > thresh) ? cfg_gran * (count + 1) : cfg_latency;
        wt = load_weight(tbl_nice[best]);
        slice = cfg_gran + (period * wt) / (wsum + wt);
        r.chosen = 6'(best);
        r.slice  = (slice > 64'hFF_FFFF) ? 24'hFF_FFFF : 24'(slice);
      end
    end
    return r;
  endfunction

  // idle stretch length, mostly none or short, now and then long
  function automatic int idle_len();
    int k;
    if (quiet) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sched_req_t random_word(input int unsigned ready_pct);
    sched_req_t w;
    int k;
    k = $urandom_range(0, 99);
    if (k < 50)      w.op = fss_pkg::OP_WRITE;
    else if (k < 80) w.op = fss_pkg::OP_PICK;
    else if (k < 97) w.op = fss_pkg::OP_STOP;
    else             w.op = OP_NONE;
    // a narrow slot range now and then, so the running slot gets rewritten
    w.slot = ($urandom_range(0, 9) < 3) ? 6'($urandom_range(0, 7)) : 6'($urandom);
    w.rdy  = ($urandom_range(0, 99) < ready_pct);
    // small runtimes give plenty of ties
    k = $urandom_range(0, 9);
    if (k < 4)       w.vr = $urandom_range(0, 15);
    else if (k < 8)  w.vr = $urandom;
    else if (k == 8) w.vr = 32'hFFFF_FFF0 | $urandom_range(0, 15);
    else             w.vr = '0;
    w.nice = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 39))
                                          : 6'($urandom_range(40, 63));
    return w;
  endfunction

  // present one request word, wait for it to be taken, then log its response;
  // called at a rising edge, leaves valid high on return
  task automatic issue(input sched_req_t w, input logic typed, input sched_rsp_t want);
    int gap;
    sched_rsp_t pred;
    gap = idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    opcode    <= w.op;
    slot      <= w.slot;
    ready_req <= w.rdy;
    vruntime  <= w.vr;
    nice      <= w.nice;
    do @(posedge clk); while (!req_ready);
    // predictor always runs so its state keeps track, hand-typed rows override
    pred = schedule_step(w);
    pending_rsp.push_back(typed ? want : pred);
  endtask

  // apb write: setup cycle, access cycle, then bus idle
  task automatic cfg_write(input logic reg_sel, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == fss_pkg::REG_LATENCY) cfg_latency = val;
    else cfg_gran = val;
    @(posedge clk);
  endtask

  // response side back-pressure
  initial begin
    int n;
    @(negedge rst);
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        rsp_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // response checker: every taken word is matched against the oldest prediction
  always @(posedge clk) begin : rsp_check
    sched_rsp_t act, exp_w;
    if (!rst && rsp_valid && rsp_ready) begin
      act = '{chosen_slot, none_ready, time_slice};
      if (pending_rsp.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("%0t: response word with none pending: slot %0d idle %0b slice %0d",
                   $realtime, act.chosen, act.idle, act.slice);
      end else begin
        exp_w = pending_rsp.pop_front();
        if (act.chosen !== exp_w.chosen || act.idle !== exp_w.idle ||
            act.slice !== exp_w.slice) begin
          bad_words++;
          if (bad_words <= 10)
            $display("%0t: mismatch exp slot %0d idle %0b slice %0d, got slot %0d idle %0b slice %0d",
                     $realtime, exp_w.chosen, exp_w.idle, exp_w.slice,
                     act.chosen, act.idle, act.slice);
        end
      end
    end
  end

  // main sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        // block must be idle before the registers change
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (p == 6) begin
          ph_latency[p] = $urandom_range(1, 65535);
          ph_gran[p]    = $urandom_range(1, 64);
        end
        cfg_write(fss_pkg::REG_LATENCY, 16'(ph_latency[p]));
        cfg_write(fss_pkg::REG_MIN_GRAN, 16'(ph_gran[p]));
      end else begin
        foreach (script[i]) issue(script[i].w, script[i].typed, script[i].want);
      end
      quiet = ph_quiet[p];
      for (int n = 0; n < ph_words[p]; n++)
        issue(random_word(ph_ready[p]), 1'b0, ZERO_RSP);
    end
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    // room for a stray word after the last pick
    repeat (150) @(posedge clk);
    if (bad_words == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
